// ===== design/cln_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cln_pkg
// Shared types, constants and helpers for the periodic cell-list search.
// ----------------------------------------------------------------------------
package cln_pkg;

    localparam int MAX_PARTICLES      = 1024;
    localparam int MAX_CELLS_PER_AXIS = 16;
    localparam int CELL_CAPACITY      = 16;
    localparam int MAX_NEIGHBORS      = 64;

    localparam int AXIS_W   = 4;                       // bits of one cell coordinate
    localparam int CELL_W   = 3 * AXIS_W;              // packed cell id
    localparam int NCELLS   = 1 << CELL_W;
    localparam int SLOT_W   = 4;                       // member slot within a cell
    localparam int MEM_W    = CELL_W + SLOT_W;
    localparam int IDX_W    = 10;
    localparam int CNT_W    = 11;
    localparam int FILL_W   = 5;
    localparam int REG_W    = 5;
    localparam int NCNT_W   = 7;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_CELLS_X = 2'd0,
        REG_CELLS_Y = 2'd1,
        REG_CELLS_Z = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  particle_index;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] pos_z;
    } t_cmd;

    typedef struct packed {
        logic [9:0] neighbor_index;
        logic       has_item;
        logic       last;
        logic       overflow;
        logic [9:0] assigned_index;
        logic [3:0] cell_x;
        logic [3:0] cell_y;
        logic [3:0] cell_z;
    } t_result;

    typedef struct packed {
        logic [REG_W-1:0] cells_x;
        logic [REG_W-1:0] cells_y;
        logic [REG_W-1:0] cells_z;
    } t_cfg;

    // Saturate a cell count register to 1..MAX_CELLS_PER_AXIS
    function automatic logic [REG_W-1:0] eff_count(input logic [REG_W-1:0] c);
        logic [REG_W-1:0] r;
        if (c == '0) begin
            r = REG_W'(1);
        end else if (c > REG_W'(MAX_CELLS_PER_AXIS)) begin
            r = REG_W'(MAX_CELLS_PER_AXIS);
        end else begin
            r = c;
        end
        return r;
    endfunction

    // Below, same and above neighbor along one axis with periodic wrap
    function automatic logic [3*AXIS_W-1:0] axis_nb(input logic [AXIS_W-1:0] n_in,
                                                    input logic [REG_W-1:0]  cnt);
        logic [REG_W-1:0] n;
        logic [REG_W-1:0] lo;
        logic [REG_W-1:0] hi;
        n  = {1'b0, n_in};
        if (n >= cnt) begin
            n = cnt - REG_W'(1);
        end
        lo = (n == '0) ? cnt - REG_W'(1) : n - REG_W'(1);
        hi = (n + REG_W'(1) == cnt) ? '0 : n + REG_W'(1);
        return {lo[AXIS_W-1:0], n[AXIS_W-1:0], hi[AXIS_W-1:0]};
    endfunction

endpackage

// ===== design/cell_list_neighbor_search_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_list_neighbor_search_top
// Periodic 3-D cell-list binning and neighbor search.
// ----------------------------------------------------------------------------
// Usage:
//  Issue a command by raising start with i_cmd while busy is low; it is
//  taken at that edge and busy rises until the command is done.
//  Results appear on o_result for one cycle each, marked by o_valid; the
//  final result of a command has last set. The receiver cannot stall.
//  Clear: one result in the next cycle, and busy for a sweep of all 4096
//  cells of the fill memory (one cell per cycle).
//  Insert: busy through the cell calculation and the fill read-modify-
//  write, one result in the cycle after the write. Op 3 and a query of an
//  unknown index: one result in the next cycle, busy stays low.
//  Query: busy while it reads the particle's cell, forms the neighbor cells,
//  then for each of the 27 cells reads the fill and, when the cell has
//  members, reads them (one member slot per cycle). Neighbors stream out
//  as found, one held back to mark the last, which lands after busy falls.
//  Reset runs the same fill sweep with busy high; config registers
//  return to 16 cells per axis and may be written any time idle.
// ----------------------------------------------------------------------------
module cell_list_neighbor_search_top
    import cln_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  t_cmd             i_cmd,
    output logic             busy,
    output logic             o_valid,
    output t_result          o_result,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [REG_W-1:0] i_cfg_data
);

    t_cfg r_cfg;

    // Hold the cell count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cells_x <= REG_W'(MAX_CELLS_PER_AXIS);
            r_cfg.cells_y <= REG_W'(MAX_CELLS_PER_AXIS);
            r_cfg.cells_z <= REG_W'(MAX_CELLS_PER_AXIS);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_CELLS_X: r_cfg.cells_x <= i_cfg_data;
                REG_CELLS_Y: r_cfg.cells_y <= i_cfg_data;
                REG_CELLS_Z: r_cfg.cells_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cln_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_start  (start),
        .i_cmd    (i_cmd),
        .o_busy   (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

// ===== design/cln_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cln_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cln_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and register the read data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/cln_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cln_engine
// Sequencer over the fill, member and particle-cell memories: clear sweep,
// insert read-modify-write, and the 27-cell neighbor scan.
// ----------------------------------------------------------------------------
module cln_engine
    import cln_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_start,
    input  t_cmd    i_cmd,
    output logic    o_busy,
    output logic    o_valid,
    output t_result o_result
);

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_INS_CALC, S_INS_RD, S_INS_WR,
        S_Q_PC, S_Q_NB, S_Q_FILL, S_Q_FWAIT, S_Q_MEM, S_Q_DRAIN, S_Q_DONE
    } t_state;

    t_state              r_state;
    logic [CELL_W-1:0]   r_clr;
    logic [CNT_W-1:0]    r_count;
    t_cmd                r_cmd;
    logic [AXIS_W-1:0]   r_cx, r_cy, r_cz;
    logic [AXIS_W-1:0]   r_nx [3];
    logic [AXIS_W-1:0]   r_ny [3];
    logic [AXIS_W-1:0]   r_nz [3];
    logic [1:0]          r_a, r_b, r_d;
    logic [FILL_W-1:0]   r_f;
    logic [FILL_W-1:0]   r_m;
    logic                r_vld;
    logic                r_pend;
    logic [IDX_W-1:0]    r_pj;
    logic [NCNT_W-1:0]   r_ecnt;
    logic                r_trunc;
    logic                r_valid;
    t_result             r_res;

    logic [REG_W-1:0]    cnx, cny, cnz;
    logic [CELL_W-1:0]   cur_cell;
    logic [CELL_W-1:0]   ins_cell;
    logic [20:0]         px, py, pz;
    logic                last_cell;

    logic                fill_we, fill_re;
    logic [CELL_W-1:0]   fill_waddr, fill_raddr;
    logic [FILL_W-1:0]   fill_wdata, fill_rdata;
    logic                mem_we, mem_re;
    logic [MEM_W-1:0]    mem_waddr, mem_raddr;
    logic [IDX_W-1:0]    mem_rdata;
    logic                pc_we, pc_re;
    logic [CELL_W-1:0]   pc_rdata;

    assign cnx = eff_count(i_cfg.cells_x);
    assign cny = eff_count(i_cfg.cells_y);
    assign cnz = eff_count(i_cfg.cells_z);
    assign px  = 21'(r_cmd.pos_x) * 21'(cnx);
    assign py  = 21'(r_cmd.pos_y) * 21'(cny);
    assign pz  = 21'(r_cmd.pos_z) * 21'(cnz);
    assign cur_cell  = {r_nx[r_a], r_ny[r_b], r_nz[r_d]};
    assign ins_cell  = {r_cx, r_cy, r_cz};
    assign last_cell = (r_a == 2'd2) && (r_b == 2'd2) && (r_d == 2'd2);

    // Drive memory ports from the state
    always_comb begin
        fill_we    = 1'b0;
        fill_waddr = ins_cell;
        fill_wdata = fill_rdata + FILL_W'(1);
        fill_re    = 1'b0;
        fill_raddr = cur_cell;
        mem_we     = 1'b0;
        mem_waddr  = {ins_cell, fill_rdata[SLOT_W-1:0]};
        mem_re     = 1'b0;
        mem_raddr  = {cur_cell, r_m[SLOT_W-1:0]};
        pc_we      = 1'b0;
        pc_re      = 1'b0;
        case (r_state)
            S_CLR: begin
                fill_we    = 1'b1;
                fill_waddr = r_clr;
                fill_wdata = '0;
            end
            S_INS_RD: begin
                fill_re    = 1'b1;
                fill_raddr = ins_cell;
            end
            S_INS_WR: begin
                if (r_count < CNT_W'(MAX_PARTICLES)) begin
                    pc_we = 1'b1;
                    if (fill_rdata < FILL_W'(CELL_CAPACITY)) begin
                        fill_we = 1'b1;
                        mem_we  = 1'b1;
                    end
                end
            end
            S_Q_PC:   pc_re   = 1'b1;
            S_Q_FILL: fill_re = 1'b1;
            S_Q_MEM:  mem_re  = 1'b1;
            default: ;
        endcase
    end

    // Sequencer, scan state and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
            r_vld   <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            r_vld   <= (r_state == S_Q_MEM);
            r_res   <= '0;

            // Check the member read last cycle and hold one candidate back
            if (r_vld && (mem_rdata > r_cmd.particle_index)) begin
                if (r_ecnt < NCNT_W'(MAX_NEIGHBORS)) begin
                    if (r_pend) begin
                        r_valid              <= 1'b1;
                        r_res.neighbor_index <= r_pj;
                        r_res.has_item       <= 1'b1;
                    end
                    r_pend <= 1'b1;
                    r_pj   <= mem_rdata;
                    r_ecnt <= r_ecnt + NCNT_W'(1);
                end else begin
                    r_trunc <= 1'b1;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_cmd <= i_cmd;
                        case (t_op'(i_cmd.op))
                            OP_CLEAR: begin
                                r_valid    <= 1'b1;
                                r_res.last <= 1'b1;
                                r_count    <= '0;
                                r_clr      <= '0;
                                r_state    <= S_CLR;
                            end
                            OP_INSERT: r_state <= S_INS_CALC;
                            OP_QUERY: begin
                                if ({1'b0, i_cmd.particle_index} >= r_count) begin
                                    r_valid    <= 1'b1;
                                    r_res.last <= 1'b1;
                                end else begin
                                    r_state <= S_Q_PC;
                                end
                            end
                            default: begin
                                r_valid    <= 1'b1;
                                r_res.last <= 1'b1;
                            end
                        endcase
                    end
                end
                S_CLR: begin
                    r_clr <= r_clr + CELL_W'(1);
                    if (r_clr == CELL_W'(NCELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_INS_CALC: begin
                    r_cx    <= px[16 +: AXIS_W];
                    r_cy    <= py[16 +: AXIS_W];
                    r_cz    <= pz[16 +: AXIS_W];
                    r_state <= S_INS_RD;
                end
                S_INS_RD: r_state <= S_INS_WR;
                S_INS_WR: begin
                    r_valid        <= 1'b1;
                    r_res.last     <= 1'b1;
                    r_res.cell_x   <= r_cx;
                    r_res.cell_y   <= r_cy;
                    r_res.cell_z   <= r_cz;
                    if (r_count >= CNT_W'(MAX_PARTICLES)) begin
                        r_res.overflow <= 1'b1;
                    end else begin
                        r_res.assigned_index <= r_count[IDX_W-1:0];
                        r_res.overflow       <= (fill_rdata >= FILL_W'(CELL_CAPACITY));
                        r_count              <= r_count + CNT_W'(1);
                    end
                    r_state <= S_IDLE;
                end
                S_Q_PC: r_state <= S_Q_NB;
                S_Q_NB: begin
                    {r_nx[0], r_nx[1], r_nx[2]} <= axis_nb(pc_rdata[2*AXIS_W +: AXIS_W], cnx);
                    {r_ny[0], r_ny[1], r_ny[2]} <= axis_nb(pc_rdata[AXIS_W +: AXIS_W], cny);
                    {r_nz[0], r_nz[1], r_nz[2]} <= axis_nb(pc_rdata[0 +: AXIS_W], cnz);
                    r_a     <= '0;
                    r_b     <= '0;
                    r_d     <= '0;
                    r_pend  <= 1'b0;
                    r_ecnt  <= '0;
                    r_trunc <= 1'b0;
                    r_state <= S_Q_FILL;
                end
                S_Q_FILL: r_state <= S_Q_FWAIT;
                S_Q_FWAIT: begin
                    r_f <= (fill_rdata > FILL_W'(CELL_CAPACITY)) ?
                           FILL_W'(CELL_CAPACITY) : fill_rdata;
                    r_m <= '0;
                    if (fill_rdata != '0) begin
                        r_state <= S_Q_MEM;
                    end else if (last_cell) begin
                        r_state <= S_Q_DONE;
                    end else begin
                        r_state <= S_Q_FILL;
                    end
                end
                S_Q_MEM: begin
                    r_m <= r_m + FILL_W'(1);
                    if (r_m + FILL_W'(1) == r_f) begin
                        r_state <= S_Q_DRAIN;
                    end
                end
                S_Q_DRAIN: begin
                    r_state <= last_cell ? S_Q_DONE : S_Q_FILL;
                end
                S_Q_DONE: begin
                    r_valid    <= 1'b1;
                    r_res.last <= 1'b1;
                    if (r_pend) begin
                        r_res.neighbor_index <= r_pj;
                        r_res.has_item       <= 1'b1;
                        r_res.overflow       <= r_trunc;
                    end
                    r_pend  <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase

            // Advance to the next of the 27 cells: z fastest, then y, then x
            if ((r_state == S_Q_DRAIN) ||
                ((r_state == S_Q_FWAIT) && (fill_rdata == '0))) begin
                if (r_d != 2'd2) begin
                    r_d <= r_d + 2'd1;
                end else begin
                    r_d <= '0;
                    if (r_b != 2'd2) begin
                        r_b <= r_b + 2'd1;
                    end else begin
                        r_b <= '0;
                        r_a <= r_a + 2'd1;
                    end
                end
            end
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

    cln_ram #(.WIDTH(FILL_W), .DEPTH(NCELLS)) u_fill (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (fill_waddr),
        .i_wdata (fill_wdata),
        .i_re    (fill_re),
        .i_raddr (fill_raddr),
        .o_rdata (fill_rdata)
    );

    cln_ram #(.WIDTH(IDX_W), .DEPTH(NCELLS * CELL_CAPACITY)) u_members (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_count[IDX_W-1:0]),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    cln_ram #(.WIDTH(CELL_W), .DEPTH(MAX_PARTICLES)) u_pcell (
        .i_clk   (i_clk),
        .i_we    (pc_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (ins_cell),
        .i_re    (pc_re),
        .i_raddr (r_cmd.particle_index),
        .o_rdata (pc_rdata)
    );

endmodule
